>>> sv/tgc_pkg.sv
// ----------------------------------------------------------------------------
// tgc_pkg
// types, event codes and register indexes of the touch gesture classifier
// ----------------------------------------------------------------------------
package tgc_pkg;

	localparam int COORD_BITS = 12;
	localparam int DW  = COORD_BITS + 1;
	localparam int MW  = (DW > 11) ? DW : 11;
	localparam int PCW = (COORD_BITS > 11) ? COORD_BITS : 11;
	localparam int CDW = PCW + 1;

	localparam int NO_CLICK_POS = -1000;

	localparam logic [3:0] EV_DOWN       = 4'd0;
	localparam logic [3:0] EV_MOVE       = 4'd1;
	localparam logic [3:0] EV_UP         = 4'd2;
	localparam logic [3:0] EV_CLICK      = 4'd3;
	localparam logic [3:0] EV_DOUBLE     = 4'd4;
	localparam logic [3:0] EV_LONG       = 4'd5;
	localparam logic [3:0] EV_LEFT       = 4'd6;
	localparam logic [3:0] EV_RIGHT      = 4'd7;
	localparam logic [3:0] EV_SWIPE_UP   = 4'd8;
	localparam logic [3:0] EV_SWIPE_DOWN = 4'd9;

	localparam logic [2:0] REG_CLICK_LIMIT  = 3'd0;
	localparam logic [2:0] REG_SWIPE_THRESH = 3'd1;
	localparam logic [2:0] REG_LONG_MS      = 3'd2;
	localparam logic [2:0] REG_DOUBLE_MS    = 3'd3;
	localparam logic [2:0] REG_DOUBLE_DIST  = 3'd4;

	typedef struct packed {
		logic [2:0]                   contact_id;
		logic signed [COORD_BITS-1:0] pos_x;
		logic signed [COORD_BITS-1:0] pos_y;
		logic                         pressed;
		logic [31:0]                  time_ms;
	} sample_t;

	typedef struct packed {
		logic [3:0]                   event_kind;
		logic signed [COORD_BITS-1:0] out_x;
		logic signed [COORD_BITS-1:0] out_y;
		logic [2:0]                   out_contact_id;
		logic                         last_of_run;
	} event_t;

	typedef struct packed {
		logic [10:0] click_move_limit;
		logic [10:0] swipe_move_threshold;
		logic [15:0] long_press_ms;
		logic [15:0] double_click_ms;
		logic [10:0] double_click_dist;
	} cfg_t;

	typedef struct packed {
		logic [3:0]                   first_kind;
		logic [3:0]                   gest_kind;
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic [2:0]                   id;
		logic                         two;
	} q_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

>>> sv/tgc_front.sv
// ----------------------------------------------------------------------------
// tgc_front
// accepts samples, tracks contacts and classifies releases into gestures
// ----------------------------------------------------------------------------
module tgc_front import tgc_pkg::*; #(
	parameter int CONTACTS = 5
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      sample_valid,
	output logic      sample_stall,
	input  sample_t   sample,
	output logic      push,
	output q_entry_t  push_data,
	input  q_status_t q_st
);

	localparam int IW = (CONTACTS > 1) ? $clog2(CONTACTS) : 1;

	logic [CONTACTS-1:0]        contact_down_q;
	logic [COORD_BITS-1:0]      start_px_q [CONTACTS];
	logic [COORD_BITS-1:0]      start_py_q [CONTACTS];
	logic [31:0]                start_stamp_q [CONTACTS];

	logic [31:0]                prev_click_stamp_q;
	logic signed [PCW-1:0]      prev_click_x_q;
	logic signed [PCW-1:0]      prev_click_y_q;

	logic                       valid_s1;
	logic [3:0]                 kind_s1;
	logic                       two_s1;
	logic signed [COORD_BITS-1:0] x_s1;
	logic signed [COORD_BITS-1:0] y_s1;
	logic [2:0]                 id_s1;
	logic signed [DW-1:0]       dx_s1;
	logic signed [DW-1:0]       dy_s1;
	logic [31:0]                dur_s1;
	logic [31:0]                time_s1;

	logic                       accept;
	logic                       id_ok;
	logic [IW-1:0]              idx;
	logic                       was;
	logic [DW-1:0]              ax;
	logic [DW-1:0]              ay;
	logic [MW-1:0]              mv;
	logic                       tap;
	logic                       long_hold;
	logic [31:0]                click_dt;
	logic signed [CDW-1:0]      cdx;
	logic signed [CDW-1:0]      cdy;
	logic [CDW-1:0]             acx;
	logic [CDW-1:0]             acy;
	logic                       dbl;
	logic [3:0]                 gest;

	assign push         = valid_s1 && !q_st.full;
	assign sample_stall = valid_s1 && q_st.full;
	assign accept       = sample_valid && !sample_stall;
	assign id_ok        = 32'(sample.contact_id) < 32'(CONTACTS);
	assign idx          = IW'(sample.contact_id);
	assign was          = contact_down_q[idx];

	// contact tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			contact_down_q <= '0;
		end else if (accept && id_ok) begin
			contact_down_q[idx] <= sample.pressed;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && id_ok && sample.pressed && !was) begin
			start_px_q[idx]    <= sample.pos_x;
			start_py_q[idx]    <= sample.pos_y;
			start_stamp_q[idx] <= sample.time_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!sample_stall) begin
			valid_s1 <= accept && id_ok && (sample.pressed || was);
		end
	end

	always_ff @(posedge clk) begin
		if (!sample_stall) begin
			kind_s1 <= !was ? EV_DOWN : (sample.pressed ? EV_MOVE : EV_UP);
			two_s1  <= was && !sample.pressed;
			x_s1    <= sample.pos_x;
			y_s1    <= sample.pos_y;
			id_s1   <= sample.contact_id;
			dx_s1   <= DW'(sample.pos_x) - DW'($signed(start_px_q[idx]));
			dy_s1   <= DW'(sample.pos_y) - DW'($signed(start_py_q[idx]));
			dur_s1  <= sample.time_ms - start_stamp_q[idx];
			time_s1 <= sample.time_ms;
		end
	end

	// gesture decision
	always_comb begin
		ax        = dx_s1[DW-1] ? DW'(-dx_s1) : DW'(dx_s1);
		ay        = dy_s1[DW-1] ? DW'(-dy_s1) : DW'(dy_s1);
		mv        = (ax > ay) ? MW'(ax) : MW'(ay);
		tap       = mv < MW'(cfg.click_move_limit);
		long_hold = dur_s1 >= 32'(cfg.long_press_ms);
		click_dt  = time_s1 - prev_click_stamp_q;
		cdx       = CDW'(x_s1) - CDW'(prev_click_x_q);
		cdy       = CDW'(y_s1) - CDW'(prev_click_y_q);
		acx       = cdx[CDW-1] ? CDW'(-cdx) : CDW'(cdx);
		acy       = cdy[CDW-1] ? CDW'(-cdy) : CDW'(cdy);
		dbl       = (click_dt < 32'(cfg.double_click_ms))
		            && (acx < CDW'(cfg.double_click_dist))
		            && (acy < CDW'(cfg.double_click_dist));
		if (tap) begin
			gest = long_hold ? EV_LONG : (dbl ? EV_DOUBLE : EV_CLICK);
		end else if (mv >= MW'(cfg.swipe_move_threshold)) begin
			if (ax > ay) begin
				gest = (dx_s1 > 0) ? EV_RIGHT : EV_LEFT;
			end else begin
				gest = (dy_s1 > 0) ? EV_SWIPE_DOWN : EV_SWIPE_UP;
			end
		end else begin
			gest = EV_CLICK;
		end
	end

	// last click record
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_click_stamp_q <= '0;
			prev_click_x_q     <= PCW'(NO_CLICK_POS);
			prev_click_y_q     <= PCW'(NO_CLICK_POS);
		end else if (push && two_s1 && tap && !long_hold) begin
			if (dbl) begin
				prev_click_stamp_q <= '0;
			end else begin
				prev_click_stamp_q <= time_s1;
				prev_click_x_q     <= PCW'(x_s1);
				prev_click_y_q     <= PCW'(y_s1);
			end
		end
	end

	always_comb begin
		push_data.first_kind = kind_s1;
		push_data.gest_kind  = gest;
		push_data.x          = x_s1;
		push_data.y          = y_s1;
		push_data.id         = id_s1;
		push_data.two        = two_s1;
	end

endmodule

>>> sv/tgc_queue.sv
// ----------------------------------------------------------------------------
// tgc_queue
// short queue of classified samples between front and back
// ----------------------------------------------------------------------------
module tgc_queue import tgc_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  q_entry_t  push_data,
	input  logic      pop,
	output q_entry_t  head,
	output q_status_t q_st
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	q_entry_t       mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign head       = mem_q[rd_ptr_q];
	assign q_st.full  = count_q == CW'(DEPTH);
	assign q_st.empty = count_q == '0;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> sv/tgc_back.sv
// ----------------------------------------------------------------------------
// tgc_back
// expands queued samples into one or two events on the output register
// ----------------------------------------------------------------------------
module tgc_back import tgc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  q_entry_t  head,
	input  q_status_t q_st,
	output logic      pop,
	output logic      evt_valid,
	input  logic      evt_stall,
	output event_t    evt
);

	logic   evt_valid_q;
	event_t evt_q;
	logic   pend_q;
	event_t pend_evt_q;
	logic   load;

	assign load      = !evt_valid_q || !evt_stall;
	assign pop       = load && !pend_q && !q_st.empty;
	assign evt_valid = evt_valid_q;
	assign evt       = evt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else if (load) begin
			if (pend_q) begin
				evt_valid_q <= 1'b1;
				pend_q      <= 1'b0;
			end else begin
				evt_valid_q <= !q_st.empty;
				pend_q      <= !q_st.empty && head.two;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (pend_q) begin
				evt_q <= pend_evt_q;
			end else begin
				evt_q.event_kind     <= head.first_kind;
				evt_q.out_x          <= head.x;
				evt_q.out_y          <= head.y;
				evt_q.out_contact_id <= head.id;
				evt_q.last_of_run    <= !head.two;
				pend_evt_q.event_kind     <= head.gest_kind;
				pend_evt_q.out_x          <= head.x;
				pend_evt_q.out_y          <= head.y;
				pend_evt_q.out_contact_id <= head.id;
				pend_evt_q.last_of_run    <= 1'b1;
			end
		end
	end

endmodule

>>> sv/touch_gesture_classifier_top.sv
// ----------------------------------------------------------------------------
// touch_gesture_classifier_top
// touch samples in, touch down/move/up and gesture events out
// ----------------------------------------------------------------------------
// A sample is taken every cycle while the queue has room. Press and hold
// samples give one event, a release gives the up event and then its gesture
// on the next load of the output register, which evt_stall can hold off, so
// a release fills the output register with two events in turn. From sample
// to first event a sample passes the accept register, the classify and queue
// write, and the output register. Samples that give no event (idle contact or
// contact number out of range) leave no trace in the queue.
// ----------------------------------------------------------------------------
module touch_gesture_classifier_top import tgc_pkg::*; #(
	parameter int CONTACTS    = 5,
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	input  logic        sample_valid,
	output logic        sample_stall,
	input  sample_t     sample,
	output logic        evt_valid,
	input  logic        evt_stall,
	output event_t      evt
);

	cfg_t      cfg_q;
	logic      push;
	q_entry_t  push_data;
	logic      pop;
	q_entry_t  head;
	q_status_t q_st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.click_move_limit     <= 11'd15;
			cfg_q.swipe_move_threshold <= 11'd60;
			cfg_q.long_press_ms        <= 16'd500;
			cfg_q.double_click_ms      <= 16'd300;
			cfg_q.double_click_dist    <= 11'd20;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CLICK_LIMIT:  cfg_q.click_move_limit     <= cfg_wdata[10:0];
				REG_SWIPE_THRESH: cfg_q.swipe_move_threshold <= cfg_wdata[10:0];
				REG_LONG_MS:      cfg_q.long_press_ms        <= cfg_wdata;
				REG_DOUBLE_MS:    cfg_q.double_click_ms      <= cfg_wdata;
				REG_DOUBLE_DIST:  cfg_q.double_click_dist    <= cfg_wdata[10:0];
				default: begin
				end
			endcase
		end
	end

	tgc_front #(
		.CONTACTS (CONTACTS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.push         (push),
		.push_data    (push_data),
		.q_st         (q_st)
	);

	tgc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.q_st      (q_st)
	);

	tgc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_st      (q_st),
		.pop       (pop),
		.evt_valid (evt_valid),
		.evt_stall (evt_stall),
		.evt       (evt)
	);

`ifndef ASSERT_OFF
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_st.full)
		else $error("queue written while full");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_st.empty)
		else $error("queue read while empty");

	a_first_of_pair_is_up: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && !evt.last_of_run |-> evt.event_kind == EV_UP)
		else $error("non-final event is not an up event");

	a_gesture_follows_up: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && !evt_stall && !evt.last_of_run |=> evt_valid && evt.last_of_run)
		else $error("gesture did not follow up event");
`endif

endmodule
